// ----- rtl/bru_pkg.sv -----
// Package for the ByteRun1 unpacker: phase codes, the command word that
// travels from the front end to the back end, and shared constants.
// No dependencies.
package bru_pkg;

	// Default width of the per-image byte counter.
	localparam int LENGTH_BITS_DEF = 24;

	// Width of the output_length register as seen on the configuration port.
	localparam int CFG_LEN_W = 24;

	// Configuration port geometry.
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	// Register index codes, taken from paddr[2].
	localparam logic REG_OUTPUT_LENGTH = 1'b0;

	// Header byte that is skipped (-128 as a signed byte).
	localparam logic [7:0] SKIP_HEADER = 8'h80;

	// Depth of the command queue; a power of two so the pointers wrap.
	localparam int QUEUE_DEPTH = 2;

	// Decoder phase.
	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_LITERAL = 2'd1,
		PH_RUN     = 2'd2
	} phase_t;

	// One command: emit count copies of value; done marks the image end.
	typedef struct packed {
		logic [7:0] value;
		logic [7:0] count;
		logic       done;
	} cmd_t;

endpackage

// ----- rtl/bru_front.sv -----
// Front end of the ByteRun1 unpacker: takes packed bytes, tracks headers,
// literal and run phases and the bytes left in the image, and issues commands.
// Depends on bru_pkg.
module bru_front #(
	parameter int LENGTH_BITS = bru_pkg::LENGTH_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   packed_byte,
	input  logic                         cfg_restart,
	input  logic [bru_pkg::CFG_LEN_W-1:0] output_length,
	input  logic                         queue_full,
	output logic                         push,
	output bru_pkg::cmd_t                push_cmd
);

	bru_pkg::phase_t        phase_q, phase_d;
	logic [7:0]             pend_q, pend_d;
	logic [LENGTH_BITS-1:0] left_q, left_d;
	logic [LENGTH_BITS-1:0] len_masked;
	logic [LENGTH_BITS-1:0] len_load;
	logic [LENGTH_BITS-1:0] pend_ext;
	logic                   accept;
	logic                   run_cut;

	// The length register is masked to the counter width; zero acts as one.
	assign len_masked = LENGTH_BITS'(output_length);
	assign len_load   = (len_masked == '0) ? LENGTH_BITS'(1) : len_masked;

	assign pend_ext = LENGTH_BITS'(pend_q);
	assign run_cut  = (pend_ext >= left_q);

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;

	// Next state of the phase, the pending count and the bytes left.
	always_comb begin
		phase_d = phase_q;
		pend_d  = pend_q;
		left_d  = left_q;
		if (cfg_restart) begin
			phase_d = bru_pkg::PH_HEADER;
			pend_d  = '0;
			left_d  = len_load;
		end else if (accept) begin
			unique case (phase_q)
				bru_pkg::PH_LITERAL: begin
					if (left_q == LENGTH_BITS'(1)) begin
						phase_d = bru_pkg::PH_HEADER;
						pend_d  = '0;
						left_d  = len_load;
					end else begin
						left_d = left_q - LENGTH_BITS'(1);
						pend_d = pend_q - 8'd1;
						if (pend_q == 8'd1) begin
							phase_d = bru_pkg::PH_HEADER;
						end
					end
				end
				bru_pkg::PH_RUN: begin
					phase_d = bru_pkg::PH_HEADER;
					pend_d  = '0;
					if (run_cut) begin
						left_d = len_load;
					end else begin
						left_d = left_q - pend_ext;
					end
				end
				default: begin
					if (!packed_byte[7]) begin
						phase_d = bru_pkg::PH_LITERAL;
						pend_d  = packed_byte + 8'd1;
					end else if (packed_byte != bru_pkg::SKIP_HEADER) begin
						phase_d = bru_pkg::PH_RUN;
						pend_d  = 8'(9'd257 - {1'b0, packed_byte});
					end else begin
						phase_d = bru_pkg::PH_HEADER;
						pend_d  = '0;
					end
				end
			endcase
		end
	end

	// Command issued for each data byte; header bytes issue nothing.
	always_comb begin
		push           = 1'b0;
		push_cmd.value = packed_byte;
		push_cmd.count = 8'd1;
		push_cmd.done  = 1'b0;
		unique case (phase_q)
			bru_pkg::PH_LITERAL: begin
				push          = accept;
				push_cmd.done = (left_q == LENGTH_BITS'(1));
			end
			bru_pkg::PH_RUN: begin
				push           = accept;
				push_cmd.count = run_cut ? left_q[7:0] : pend_q;
				push_cmd.done  = run_cut;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bru_pkg::PH_HEADER;
			pend_q  <= '0;
			left_q  <= LENGTH_BITS'(1);
		end else begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			left_q  <= left_d;
		end
	end

endmodule

// ----- rtl/bru_queue.sv -----
// Short command queue between the front and back ends of the unpacker.
// Depends on bru_pkg for the command word and the depth.
module bru_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bru_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output bru_pkg::cmd_t pop_cmd
);

	localparam int PTR_W = (bru_pkg::QUEUE_DEPTH > 1) ? $clog2(bru_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(bru_pkg::QUEUE_DEPTH + 1);

	bru_pkg::cmd_t    mem_q [bru_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(bru_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = mem_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	// Storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/bru_back.sv -----
// Back end of the unpacker: carries out commands, one or two bytes a word,
// into a registered output stage.
// Depends on bru_pkg for the command word.
module bru_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  bru_pkg::cmd_t cmd_in,
	output logic          cmd_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    first_byte,
	output logic [7:0]    second_byte,
	output logic [1:0]    byte_count,
	output logic          run_end,
	output logic          image_done
);

	logic       busy_q;
	logic [7:0] value_q;
	logic [7:0] rem_q;
	logic       done_q;
	logic       out_valid_q;
	logic [7:0] first_q, second_q;
	logic [1:0] count_q;
	logic       end_q, idone_q;
	logic       load_ok, emit, last, pair;

	assign load_ok = !out_valid_q || !out_stall;
	assign emit    = busy_q && load_ok;
	assign last    = (rem_q <= 8'd2);
	assign pair    = (rem_q >= 8'd2);
	assign cmd_pop = cmd_valid && (!busy_q || (emit && last));

	// Command in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd_pop) begin
			busy_q <= 1'b1;
		end else if (emit && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			value_q <= cmd_in.value;
			rem_q   <= cmd_in.count;
			done_q  <= cmd_in.done;
		end else if (emit) begin
			rem_q <= rem_q - (pair ? 8'd2 : 8'd1);
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			first_q  <= value_q;
			second_q <= pair ? value_q : 8'd0;
			count_q  <= pair ? 2'd2 : 2'd1;
			end_q    <= last;
			idone_q  <= last && done_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign first_byte  = first_q;
	assign second_byte = second_q;
	assign byte_count  = count_q;
	assign run_end     = end_q;
	assign image_done  = idone_q;

	// A valid word carries one or two bytes.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_q == 2'd1 || count_q == 2'd2))
		else $error("output word with bad byte count");

	// The image end is always the last word of its command.
	a_done_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && idone_q) |-> end_q)
		else $error("image end flagged inside a run");

	// A single-byte word has a cleared second byte.
	a_single_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && count_q == 2'd1) |-> (second_q == 8'd0))
		else $error("second byte set on single-byte word");

	// A command in progress never has an empty remainder.
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != 8'd0))
		else $error("command in progress with no bytes left");

endmodule

// ----- rtl/byterun1_unpacker.sv -----
// ByteRun1 (PackBits) unpacker, top level: configuration register, front end,
// command queue and back end. Depends on bru_pkg, bru_front, bru_queue, bru_back.
//
// Use: packed bytes enter on packed_byte with in_valid/in_stall, one per word.
// Unpacked bytes leave as words of one or two bytes on out_valid/out_stall with
// byte_count, run_end and image_done. A literal byte gives one word; a run of n
// bytes gives ceil(n/2) words, two bytes each but for an odd last one. Header
// bytes give nothing. output_length (register 0, address 0 on the APB port) sets
// the bytes per image; writing it restarts the image and the user must do it only
// while idle; the block does not check. A data byte passes the queue, the back
// end's command registers and the output register. Throughput: one packed byte
// a cycle for literals while in_stall is low; a run holds the back end for all
// its words. The two-entry queue fills and in_stall rises until the run drains.
// A stalled output word holds; the back end and then the queue stop behind it.
// Reset clears all control state, sets output_length to 1 and expects a header.
module byterun1_unpacker #(
	parameter int LENGTH_BITS = bru_pkg::LENGTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bru_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [bru_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [bru_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     packed_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     first_byte,
	output logic [7:0]                     second_byte,
	output logic [1:0]                     byte_count,
	output logic                           run_end,
	output logic                           image_done
);

	logic [bru_pkg::CFG_LEN_W-1:0] output_length_q;
	logic                          cfg_wr;
	logic                          queue_full;
	logic                          push;
	bru_pkg::cmd_t                 push_cmd;
	logic                          pop;
	logic                          pop_valid;
	bru_pkg::cmd_t                 pop_cmd;

	// Configuration register; writes outside the list are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == bru_pkg::REG_OUTPUT_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_length_q <= bru_pkg::CFG_LEN_W'(1);
		end else if (cfg_wr) begin
			output_length_q <= pwdata[bru_pkg::CFG_LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == bru_pkg::REG_OUTPUT_LENGTH) begin
			prdata = bru_pkg::CFG_DATA_W'(output_length_q);
		end
	end

	bru_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.packed_byte  (packed_byte),
		.cfg_restart  (cfg_wr),
		.output_length(pwdata[bru_pkg::CFG_LEN_W-1:0] & {bru_pkg::CFG_LEN_W{cfg_wr}}
			| output_length_q & {bru_pkg::CFG_LEN_W{!cfg_wr}}),
		.queue_full   (queue_full),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	bru_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.pop_valid(pop_valid),
		.pop_cmd  (pop_cmd)
	);

	bru_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (pop_valid),
		.cmd_in     (pop_cmd),
		.cmd_pop    (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.first_byte (first_byte),
		.second_byte(second_byte),
		.byte_count (byte_count),
		.run_end    (run_end),
		.image_done (image_done)
	);

endmodule
